@@ rtl/core/latency_welford_accumulator_assert.svh @@
// Assertion macros shared by the accumulator RTL.
// Simulation builds get concurrent assertions that report through $error.
// Synthesis builds see empty macros.
`ifndef LATENCY_WELFORD_ACCUMULATOR_ASSERT_SVH
`define LATENCY_WELFORD_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising edge while reset is low.
`define LWA_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define LWA_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define LWA_ASSERT(label, clock, reset, prop, msg)
`define LWA_ASSERT_ALWAYS(label, clock, prop, msg)
`endif
`endif

@@ rtl/core/lwa_pkg.sv @@
package lwa_pkg;

  // Field widths.
  localparam int COUNT_W = 20;
  localparam int MEAN_W  = 56;
  localparam int SUM_W   = 64;
  localparam int SEC_W   = 32;
  localparam int NS_W    = 30;
  localparam int WORD_W  = 32;

  // Latency is clamped to LAT_W bits and carries FRAC_W fraction bits in the mean.
  localparam int LAT_W  = 40;
  localparam int FRAC_W = 16;

  // Deviations are magnitudes below 2^MAG_W.
  localparam int MAG_W     = MEAN_W;
  localparam int MAG_CNT_W = $clog2(MAG_W);

  // The deviation product drops its low MUL_DROP_W bits and keeps SUM_W bits above them.
  localparam int MUL_DROP_W    = 32;
  localparam int MUL_LO_KEEP_W = MAG_W - MUL_DROP_W;
  localparam int MUL_HI_KEEP_W = SUM_W - MUL_LO_KEEP_W;

  // Whole-second differences of 2^SEC_MAG_W or more always clamp.
  localparam int SEC_MAG_W    = 11;
  localparam int SEC_CNT_W    = $clog2(SEC_MAG_W);
  localparam int LAT_PROD_W   = SEC_MAG_W + NS_W;
  localparam int LAT_SUM_W    = LAT_PROD_W + 2;

  localparam logic [NS_W-1:0]    NS_PER_S          = NS_W'(1000000000);
  localparam logic [LAT_W-1:0]   LAT_MAX           = {LAT_W{1'b1}};
  localparam logic [COUNT_W-1:0] MAX_SAMPLES_RESET = COUNT_W'(1000000);

  // Handshake status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } lwa_unit_stat_t;

endpackage

@@ rtl/core/lwa_div.sv @@
`include "latency_welford_accumulator_assert.svh"

// Restoring divider, one quotient bit per cycle, MSB first.
module lwa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lwa_pkg::MAG_W-1:0]    dividend,
  input  logic [lwa_pkg::COUNT_W-1:0]  divisor,
  output lwa_pkg::lwa_unit_stat_t      stat,
  output logic [lwa_pkg::MAG_W-1:0]    quotient
);
  import lwa_pkg::*;

  logic                 busy;
  logic                 done;
  logic [MAG_CNT_W-1:0] cnt;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   dvs;
  logic [MAG_W-1:0]     quo;

  logic [COUNT_W:0]     trial;
  logic                 fits;

  // Bring down the next dividend bit and try the divisor against it.
  always_comb begin
    trial = {rem, quo[MAG_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      dvs  <= divisor;
      quo  <= dividend;
    end else if (busy) begin
      rem  <= fits ? COUNT_W'(trial - {1'b0, dvs}) : trial[COUNT_W-1:0];
      quo  <= {quo[MAG_W-2:0], fits};
      cnt  <= cnt + 1'b1;
      if (cnt == MAG_CNT_W'(MAG_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

  `LWA_ASSERT(a_div_done_pulse, clk, rst, done |=> !done, "divider done held longer than one cycle")
  `LWA_ASSERT(a_div_rem_below, clk, rst, busy |-> rem < dvs, "divider remainder not below divisor")
  `LWA_ASSERT(a_div_no_restart, clk, rst, busy |-> !start, "divider restarted while busy")

endmodule

@@ rtl/core/lwa_mul.sv @@
`include "latency_welford_accumulator_assert.svh"

// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Gives the product shifted right by 32 bits, saturated to 64 bits.
module lwa_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lwa_pkg::MAG_W-1:0]  mcand,
  input  logic [lwa_pkg::MAG_W-1:0]  mplier,
  output lwa_pkg::lwa_unit_stat_t    stat,
  output logic [lwa_pkg::SUM_W-1:0]  product
);
  import lwa_pkg::*;

  logic                 busy;
  logic                 done;
  logic [MAG_CNT_W-1:0] cnt;
  logic [MAG_W-1:0]     ma;
  logic [MAG_W-1:0]     mb;
  logic [MAG_W-1:0]     acc;
  logic [MAG_W-1:0]     lo;
  logic [MAG_W:0]       psum;
  logic                 sat;

  // Add the multiplicand when the current multiplier bit is set.
  always_comb begin
    psum = {1'b0, acc} + (mb[0] ? {1'b0, ma} : '0);
  end

  // The partial sum shifts right; its low bit drops into the low product half.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      ma   <= mcand;
      mb   <= mplier;
      acc  <= '0;
    end else if (busy) begin
      acc <= psum[MAG_W:1];
      lo  <= {psum[0], lo[MAG_W-1:1]};
      mb  <= {1'b0, mb[MAG_W-1:1]};
      cnt <= cnt + 1'b1;
      if (cnt == MAG_CNT_W'(MAG_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Anything at or above bit 96 of the full product saturates.
  always_comb begin
    sat     = |acc[MAG_W-1:MUL_HI_KEEP_W];
    product = sat ? {SUM_W{1'b1}} : {acc[MUL_HI_KEEP_W-1:0], lo[MAG_W-1:MUL_DROP_W]};
  end

  assign stat.busy = busy;
  assign stat.done = done;

  `LWA_ASSERT(a_mul_done_pulse, clk, rst, done |=> !done, "multiplier done held too long")
  `LWA_ASSERT(a_mul_no_restart, clk, rst, busy |-> !start, "multiplier restarted while busy")
  `LWA_ASSERT(a_mul_done_after_busy, clk, rst, $rose(done) |-> $past(busy), "done without work")

endmodule

@@ rtl/core/latency_welford_accumulator.sv @@
// Latency Welford accumulator: running mean and squared-deviation sum of echo latencies.
// A good word passes through the seconds-to-ns shift-add, the bit-serial divider and the
// bit-serial multiplier before its result is registered; an ignored or rejected word goes
// straight to the result register. A stalled result adds its stall. No new word is taken
// until the result of the last one has been registered (req_stall is high outside idle).
// Reset (rst, synchronous): clears the statistics and the stop flag, max_samples -> 1000000.
`include "latency_welford_accumulator_assert.svh"

module latency_welford_accumulator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_enable,
  input  logic [lwa_pkg::COUNT_W-1:0]  cfg_write_data,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [lwa_pkg::SEC_W-1:0]    start_seconds,
  input  logic [lwa_pkg::NS_W-1:0]     start_nanoseconds,
  input  logic [lwa_pkg::SEC_W-1:0]    end_seconds,
  input  logic [lwa_pkg::NS_W-1:0]     end_nanoseconds,
  input  logic [lwa_pkg::WORD_W-1:0]   challenge_word,
  input  logic [lwa_pkg::WORD_W-1:0]   response_word,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         accepted,
  output logic                         halted,
  output logic [lwa_pkg::COUNT_W-1:0]  sample_count,
  output logic [lwa_pkg::MEAN_W-1:0]   mean_latency,
  output logic [lwa_pkg::SUM_W-1:0]    squared_deviation_sum
);
  import lwa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAT_MUL,
    ST_LAT_FIX,
    ST_DOLD,
    ST_DIV,
    ST_MEAN,
    ST_DNEW,
    ST_MUL,
    ST_SUM,
    ST_FINISH
  } state_t;

  state_t state;

  // Statistics and control.
  logic                 stopped;
  logic [COUNT_W-1:0]   count;
  logic [MEAN_W-1:0]    running_mean;
  logic [SUM_W-1:0]     deviation_sum;
  logic [COUNT_W-1:0]   max_samples;
  logic                 item_ok;

  // Latency datapath.
  logic [SEC_CNT_W-1:0] sec_cnt;
  logic [SEC_MAG_W-1:0] sec_mag;
  logic                 sec_neg;
  logic                 sec_big;
  logic [NS_W:0]        dn;
  logic [NS_W-1:0]      lat_acc;
  logic [SEC_MAG_W-1:0] lat_lo;
  logic [MEAN_W-1:0]    lat_x;
  logic                 dold_neg;
  logic [MAG_W-1:0]     dold_mag;
  logic                 dnew_neg;

  // Combinational helpers.
  logic                 req_take;
  logic                 rsp_free;
  logic                 reject;
  logic                 ds_neg;
  logic [SEC_W-1:0]     ds_mag;
  logic [NS_W:0]        lat_step;
  logic [LAT_PROD_W-1:0] lat_prod;
  logic [LAT_SUM_W-1:0] lat_dn;
  logic [LAT_SUM_W-1:0] lat_pe;
  logic [LAT_SUM_W-1:0] lat_sum;
  logic [LAT_W-1:0]     lat_clamp;
  logic                 cur_neg;
  logic [MAG_W-1:0]     cur_mag;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_next;
  logic [MEAN_W-1:0]    mean_next;

  // Serial units.
  lwa_unit_stat_t       div_stat;
  lwa_unit_stat_t       mul_stat;
  logic [MAG_W-1:0]     div_quotient;
  logic [SUM_W-1:0]     mul_product;
  logic                 div_start;
  logic                 mul_start;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign div_start = (state == ST_DOLD);
  assign mul_start = (state == ST_DNEW);

  // Word checks and the whole-second difference as sign and magnitude.
  always_comb begin
    reject = (count >= max_samples) || (response_word != WORD_W'(challenge_word + 1'b1));
    ds_neg = end_seconds < start_seconds;
    ds_mag = ds_neg ? SEC_W'(start_seconds - end_seconds)
                    : SEC_W'(end_seconds - start_seconds);
  end

  // One step of seconds times 1e9, and the signed latency with its clamp.
  always_comb begin
    lat_step = {1'b0, lat_acc} + (sec_mag[0] ? {1'b0, NS_PER_S} : '0);
    lat_prod = {lat_acc, lat_lo};
    lat_dn   = {{(LAT_SUM_W - NS_W - 1){dn[NS_W]}}, dn};
    lat_pe   = {{(LAT_SUM_W - LAT_PROD_W){1'b0}}, lat_prod};
    lat_sum  = sec_neg ? LAT_SUM_W'(lat_dn - lat_pe) : LAT_SUM_W'(lat_dn + lat_pe);
    if (sec_big) begin
      lat_clamp = sec_neg ? '0 : LAT_MAX;
    end else if (lat_sum[LAT_SUM_W-1]) begin
      lat_clamp = '0;
    end else if (|lat_sum[LAT_SUM_W-2:LAT_W]) begin
      lat_clamp = LAT_MAX;
    end else begin
      lat_clamp = lat_sum[LAT_W-1:0];
    end
  end

  // Deviation of the scaled sample from the current mean, as sign and magnitude.
  always_comb begin
    cur_neg = lat_x < running_mean;
    cur_mag = cur_neg ? MAG_W'(running_mean - lat_x) : MAG_W'(lat_x - running_mean);
  end

  // Mean step and the saturating or clamping update of the deviation sum.
  always_comb begin
    mean_next = dold_neg ? MEAN_W'(running_mean - div_quotient)
                         : MEAN_W'(running_mean + div_quotient);
    sum_add   = {1'b0, deviation_sum} + {1'b0, mul_product};
    if (dold_neg == dnew_neg) begin
      sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    end else if (deviation_sum < mul_product) begin
      sum_next = '0;
    end else begin
      sum_next = SUM_W'(deviation_sum - mul_product);
    end
  end

  lwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur_mag),
    .divisor  (COUNT_W'(count + 1'b1)),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  lwa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (dold_mag),
    .mplier  (cur_mag),
    .stat    (mul_stat),
    .product (mul_product)
  );

  // Sequencer, statistics and the output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      stopped       <= 1'b0;
      count         <= '0;
      running_mean  <= '0;
      deviation_sum <= '0;
      max_samples   <= MAX_SAMPLES_RESET;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        max_samples <= cfg_write_data;
      end

      // A word that leaves with no new word behind it clears the valid.
      if (rsp_valid && !rsp_stall && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_take) begin
            item_ok <= 1'b0;
            if (stopped) begin
              state <= ST_FINISH;
            end else if (reject) begin
              stopped <= 1'b1;
              state   <= ST_FINISH;
            end else begin
              sec_neg <= ds_neg;
              sec_big <= |ds_mag[SEC_W-1:SEC_MAG_W];
              sec_mag <= ds_mag[SEC_MAG_W-1:0];
              dn      <= {1'b0, end_nanoseconds} - {1'b0, start_nanoseconds};
              lat_acc <= '0;
              sec_cnt <= '0;
              state   <= ST_LAT_MUL;
            end
          end
        end
        ST_LAT_MUL: begin
          lat_acc <= lat_step[NS_W:1];
          lat_lo  <= {lat_step[0], lat_lo[SEC_MAG_W-1:1]};
          sec_mag <= {1'b0, sec_mag[SEC_MAG_W-1:1]};
          sec_cnt <= sec_cnt + 1'b1;
          if (sec_cnt == SEC_CNT_W'(SEC_MAG_W - 1)) begin
            state <= ST_LAT_FIX;
          end
        end
        ST_LAT_FIX: begin
          lat_x <= {lat_clamp, {FRAC_W{1'b0}}};
          state <= ST_DOLD;
        end
        ST_DOLD: begin
          dold_neg <= cur_neg;
          dold_mag <= cur_mag;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          running_mean <= mean_next;
          count        <= count + 1'b1;
          state        <= ST_DNEW;
        end
        ST_DNEW: begin
          dnew_neg <= cur_neg;
          state    <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          deviation_sum <= sum_next;
          item_ok       <= 1'b1;
          if (count >= max_samples) begin
            stopped <= 1'b1;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp_valid             <= 1'b1;
            accepted              <= item_ok;
            halted                <= stopped;
            sample_count          <= count;
            mean_latency          <= running_mean;
            squared_deviation_sum <= deviation_sum;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LWA_ASSERT(a_stopped_freezes_count, clk, rst, stopped |=> $stable(count), "count moved after stop")
  `LWA_ASSERT(a_stop_only_at_finish, clk, rst, $rose(stopped) |-> state == ST_FINISH, "stop set out of sequence")
  `LWA_ASSERT(a_units_exclusive, clk, rst, !(div_stat.busy && mul_stat.busy), "divider and multiplier overlap")
  `LWA_ASSERT(a_accepted_has_count, clk, rst, (rsp_valid && accepted) |-> sample_count != '0, "accepted word with zero count")

endmodule
